@@ design/vertex_affine_projective_transform_top_defines.svh @@
// assertion macros shared by the checker
`ifndef VERTEX_AFFINE_PROJECTIVE_TRANSFORM_TOP_DEFINES_SVH
`define VERTEX_AFFINE_PROJECTIVE_TRANSFORM_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define VAPT_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("vapt check failed");

// next-cycle implication, disabled in reset
`define VAPT_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("vapt check failed");

`endif

@@ design/vapt_pkg.sv @@
package vapt_pkg;

    localparam int COEF_FRAC = 12;
    localparam int VERT_FRAC = 16;

    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_AFFINE     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LINEAR     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PROJECTIVE = 2'd2;
    // bit that selects the divide path
    localparam int CMD_PROJ_BIT = 1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PERSP    = 3'd6;

    typedef struct packed {
        logic proj;
        logic dz;
        logic neg_x;
        logic neg_y;
        logic sat;
    } item_flags_t;

    localparam int FLAGS_W = $bits(item_flags_t);

endpackage

@@ design/vapt_front.sv @@
module vapt_front #(
    parameter int VW = 32,
    parameter int CW = 20,
    localparam int DW = VW + CW + 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [vapt_pkg::CMD_W-1:0]    command,
    input  logic signed [VW-1:0]          vertex_x,
    input  logic signed [VW-1:0]          vertex_y,
    input  logic signed [VW-1:0]          vertex_z,
    input  logic [3*CW-1:0]               row0,
    input  logic [3*CW-1:0]               row1,
    input  logic [3*CW-1:0]               row2,
    input  logic [3*CW-1:0]               persp,
    input  logic signed [VW-1:0]          off_x,
    input  logic signed [VW-1:0]          off_y,
    input  logic signed [VW-1:0]          off_z,
    input  logic                          q_full,
    output logic                          q_push,
    output vapt_pkg::item_flags_t         q_flags,
    output logic [VW-1:0]                 q_rx,
    output logic [VW-1:0]                 q_ry,
    output logic [VW-1:0]                 q_rz,
    output logic [DW-1:0]                 q_nx,
    output logic [DW-1:0]                 q_ny,
    output logic [DW-1:0]                 q_den
);

    localparam int PW = VW + CW;
    localparam logic signed [DW:0] HALF = (DW+1)'(1) << (vapt_pkg::COEF_FRAC - 1);
    localparam logic signed [DW:0] MAXV = {{(DW-VW+2){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [DW:0] MINV = ~MAXV;

    logic fe;

    logic                       s0_valid_reg;
    logic [vapt_pkg::CMD_W-1:0] s0_cmd_reg;
    logic signed [VW-1:0]       s0_v_reg [3];

    logic                       s1_valid_reg;
    logic [vapt_pkg::CMD_W-1:0] s1_cmd_reg;
    logic signed [VW-1:0]       s1_vz_reg;
    logic signed [PW-1:0]       p_reg [4][3];
    logic signed [PW-1:0]       p_next [4][3];

    logic                       s2_valid_reg;
    logic [vapt_pkg::CMD_W-1:0] s2_cmd_reg;
    logic signed [VW-1:0]       s2_vz_reg;
    logic signed [DW-1:0]       dot_reg [4];
    logic signed [DW-1:0]       dot_next [4];

    logic                       s3_valid_reg;
    vapt_pkg::item_flags_t      s3_flags_reg, s3_flags_next;
    logic [VW-1:0]              s3_r_reg [3];
    logic [VW-1:0]              s3_r_next [3];
    logic [DW-1:0]              s3_nx_reg, s3_ny_reg, s3_den_reg;
    logic [DW-1:0]              s3_nx_next, s3_ny_next, s3_den_next;

    logic [3*CW-1:0]            rows [4];

    assign rows[0] = row0;
    assign rows[1] = row1;
    assign rows[2] = row2;
    assign rows[3] = persp;

    assign fe       = !(s3_valid_reg && q_full);
    assign in_stall = !fe;
    assign q_push   = s3_valid_reg && !q_full;

    // nine matrix products and three perspective products
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p_next[r][k] = $signed(rows[r][k*CW +: CW]) * s0_v_reg[k];
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            dot_next[r] = DW'(p_reg[r][0]) + DW'(p_reg[r][1]) + DW'(p_reg[r][2]);
        end
    end

    // rounding, offset and clamp for the matrix modes; signs and magnitudes for divide
    always_comb
    begin
        logic signed [DW:0]   acc;
        logic signed [DW:0]   t;
        logic signed [VW-1:0] offs [3];
        logic                 affine;
        logic                 sat;
        logic [DW-1:0]        den;

        offs[0] = off_x;
        offs[1] = off_y;
        offs[2] = off_z;
        affine  = (s2_cmd_reg == vapt_pkg::CMD_AFFINE);
        sat     = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            acc = $signed({dot_reg[k][DW-1], dot_reg[k]}) + HALF;
            t   = acc >>> vapt_pkg::COEF_FRAC;
            if (affine)
            begin
                t = t + $signed({{(DW+1-VW){offs[k][VW-1]}}, offs[k]});
            end
            if (t > MAXV)
            begin
                sat = 1'b1;
                t   = MAXV;
            end
            else if (t < MINV)
            begin
                sat = 1'b1;
                t   = MINV;
            end
            s3_r_next[k] = t[VW-1:0];
        end

        den = dot_reg[3];
        s3_flags_next.proj  = s2_cmd_reg[vapt_pkg::CMD_PROJ_BIT];
        s3_flags_next.dz    = (den == '0);
        s3_flags_next.neg_x = dot_reg[0][DW-1] ^ (!s3_flags_next.dz && den[DW-1]);
        s3_flags_next.neg_y = dot_reg[1][DW-1] ^ (!s3_flags_next.dz && den[DW-1]);
        s3_flags_next.sat   = sat;
        s3_nx_next  = dot_reg[0][DW-1] ? (~dot_reg[0] + DW'(1)) : dot_reg[0];
        s3_ny_next  = dot_reg[1][DW-1] ? (~dot_reg[1] + DW'(1)) : dot_reg[1];
        s3_den_next = den[DW-1] ? (~den + DW'(1)) : den;
        if (s3_flags_next.proj)
        begin
            s3_r_next[2] = s2_vz_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (fe)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            s0_cmd_reg   <= command;
            s0_v_reg[0]  <= vertex_x;
            s0_v_reg[1]  <= vertex_y;
            s0_v_reg[2]  <= vertex_z;
            s1_cmd_reg   <= s0_cmd_reg;
            s1_vz_reg    <= s0_v_reg[2];
            p_reg        <= p_next;
            s2_cmd_reg   <= s1_cmd_reg;
            s2_vz_reg    <= s1_vz_reg;
            dot_reg      <= dot_next;
            s3_flags_reg <= s3_flags_next;
            s3_r_reg     <= s3_r_next;
            s3_nx_reg    <= s3_nx_next;
            s3_ny_reg    <= s3_ny_next;
            s3_den_reg   <= s3_den_next;
        end
    end

    assign q_flags = s3_flags_reg;
    assign q_rx    = s3_r_reg[0];
    assign q_ry    = s3_r_reg[1];
    assign q_rz    = s3_r_reg[2];
    assign q_nx    = s3_nx_reg;
    assign q_ny    = s3_ny_reg;
    assign q_den   = s3_den_reg;

endmodule

@@ design/vapt_fifo.sv @@
module vapt_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty
);

    localparam int DEPTH = 2;

    logic [W-1:0] mem_reg [DEPTH];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   count_reg;

    assign full  = (count_reg == 2'(DEPTH));
    assign empty = (count_reg == 2'd0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

@@ design/vapt_back.sv @@
module vapt_back #(
    parameter int VW = 32,
    parameter int CW = 20,
    localparam int DW = VW + CW + 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  vapt_pkg::item_flags_t q_flags,
    input  logic [VW-1:0]         q_rx,
    input  logic [VW-1:0]         q_ry,
    input  logic [VW-1:0]         q_rz,
    input  logic [DW-1:0]         q_nx,
    input  logic [DW-1:0]         q_ny,
    input  logic [DW-1:0]         q_den,
    input  logic signed [VW-1:0]  off_x,
    input  logic signed [VW-1:0]  off_y,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VW-1:0]         result_x,
    output logic [VW-1:0]         result_y,
    output logic [VW-1:0]         result_z,
    output logic                  saturated,
    output logic                  divide_by_zero
);

    localparam int NW = DW + vapt_pkg::VERT_FRAC;
    localparam int NS = VW + 2;
    localparam int QW = VW + 1;
    localparam logic [QW-1:0] LIM = QW'(1) << VW;
    localparam logic signed [VW+2:0] MAXO = {4'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW+2:0] MINO = ~MAXO;
    localparam logic [VW-1:0] MAXR = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] MINR = ~MAXR;

    logic be;

    logic                  sv_reg   [NS];
    vapt_pkg::item_flags_t sf_reg   [NS];
    logic [VW-1:0]         sx_reg   [NS];
    logic [VW-1:0]         sy_reg   [NS];
    logic [VW-1:0]         sz_reg   [NS];
    logic [DW-1:0]         sd_reg   [NS];
    logic [NW-1:0]         remx_reg [NS];
    logic [NW-1:0]         remy_reg [NS];
    logic [QW-1:0]         qx_reg   [NS];
    logic [QW-1:0]         qy_reg   [NS];
    logic                  ovx_reg  [NS];
    logic                  ovy_reg  [NS];

    logic [NW-1:0] nx_full, ny_full;

    logic                  out_valid_reg;
    logic [VW-1:0]         rx_reg, ry_reg, rz_reg;
    logic [VW-1:0]         rx_next, ry_next;
    logic                  sat_reg, sat_next, dz_reg;

    assign be    = !(out_valid_reg && out_stall);
    assign q_pop = be && !q_empty;

    assign nx_full = {q_nx, {vapt_pkg::VERT_FRAC{1'b0}}};
    assign ny_full = {q_ny, {vapt_pkg::VERT_FRAC{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg[0] <= 1'b0;
        end
        else if (be)
        begin
            sv_reg[0] <= !q_empty;
        end
    end

    // load stage: quotient of 2^(VW+1) or more is clamped anyway
    always_ff @(posedge clk)
    begin
        if (be)
        begin
            sf_reg[0]   <= q_flags;
            sx_reg[0]   <= q_rx;
            sy_reg[0]   <= q_ry;
            sz_reg[0]   <= q_rz;
            sd_reg[0]   <= q_den;
            remx_reg[0] <= nx_full;
            remy_reg[0] <= ny_full;
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            ovx_reg[0]  <= (nx_full >> (VW + 1)) >= NW'(q_den);
            ovy_reg[0]  <= (ny_full >> (VW + 1)) >= NW'(q_den);
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar s = 1; s < NS; s++)
    begin : g_div
        localparam int B = NS - 1 - s;
        logic [NW-1:0] dd;
        logic          tx, ty;
        logic [QW-1:0] qx_next, qy_next;

        always_comb
        begin
            dd      = NW'(sd_reg[s-1]);
            tx      = (remx_reg[s-1] >> B) >= dd;
            ty      = (remy_reg[s-1] >> B) >= dd;
            qx_next = qx_reg[s-1];
            qy_next = qy_reg[s-1];
            qx_next[B] = tx;
            qy_next[B] = ty;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[s] <= 1'b0;
            end
            else if (be)
            begin
                sv_reg[s] <= sv_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (be)
            begin
                sf_reg[s]   <= sf_reg[s-1];
                sx_reg[s]   <= sx_reg[s-1];
                sy_reg[s]   <= sy_reg[s-1];
                sz_reg[s]   <= sz_reg[s-1];
                sd_reg[s]   <= sd_reg[s-1];
                remx_reg[s] <= tx ? remx_reg[s-1] - (dd << B) : remx_reg[s-1];
                remy_reg[s] <= ty ? remy_reg[s-1] - (dd << B) : remy_reg[s-1];
                qx_reg[s]   <= qx_next;
                qy_reg[s]   <= qy_next;
                ovx_reg[s]  <= ovx_reg[s-1];
                ovy_reg[s]  <= ovy_reg[s-1];
            end
        end
    end

    // clamp quotient, apply sign and offset, saturate
    always_comb
    begin
        vapt_pkg::item_flags_t f;
        logic [QW-1:0]         mx, my;
        logic signed [VW+1:0]  vx, vy;
        logic signed [VW+2:0]  tx, ty;
        logic                  cx, cy;

        f  = sf_reg[NS-1];
        mx = (ovx_reg[NS-1] || qx_reg[NS-1] > LIM) ? LIM : qx_reg[NS-1];
        my = (ovy_reg[NS-1] || qy_reg[NS-1] > LIM) ? LIM : qy_reg[NS-1];
        vx = f.neg_x ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
        vy = f.neg_y ? -$signed({1'b0, my}) : $signed({1'b0, my});
        tx = $signed({vx[VW+1], vx}) + $signed({{3{off_x[VW-1]}}, off_x});
        ty = $signed({vy[VW+1], vy}) + $signed({{3{off_y[VW-1]}}, off_y});
        cx = (tx > MAXO) || (tx < MINO);
        cy = (ty > MAXO) || (ty < MINO);
        if (tx > MAXO)
        begin
            tx = MAXO;
        end
        else if (tx < MINO)
        begin
            tx = MINO;
        end
        if (ty > MAXO)
        begin
            ty = MAXO;
        end
        else if (ty < MINO)
        begin
            ty = MINO;
        end

        if (!f.proj)
        begin
            rx_next  = sx_reg[NS-1];
            ry_next  = sy_reg[NS-1];
            sat_next = f.sat;
        end
        else if (f.dz)
        begin
            rx_next  = f.neg_x ? MINR : MAXR;
            ry_next  = f.neg_y ? MINR : MAXR;
            sat_next = 1'b1;
        end
        else
        begin
            rx_next  = tx[VW-1:0];
            ry_next  = ty[VW-1:0];
            sat_next = cx || cy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (be)
        begin
            out_valid_reg <= sv_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            rz_reg  <= sz_reg[NS-1];
            sat_reg <= sat_next;
            dz_reg  <= sf_reg[NS-1].proj && sf_reg[NS-1].dz;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_x       = rx_reg;
    assign result_y       = ry_reg;
    assign result_z       = rz_reg;
    assign saturated      = sat_reg;
    assign divide_by_zero = dz_reg;

endmodule

@@ design/vertex_affine_projective_transform_top.sv @@
// vertex transform: one signed fixed-point vertex (x, y, z) plus a command in, one
// transformed vertex out. command 0 = matrix times vertex plus offset, 1 = matrix only,
// 2 (and 3) = rows 0 and 1 divided by the perspective dot product plus offset, z passed
// through. coefficients are signed with 12 fraction bits, packed three per register,
// element 0 lowest. results clamp to the vertex range and raise saturated; a zero divisor
// forces x and y to the extreme matching the numerator sign and raises divide_by_zero.
// throughput is one transaction per clock while no stall holds the flow; a result passes
// four front stages, the two-entry queue, the divider (one quotient bit per stage) and
// the output register.
// configuration writes are always ready and take effect at once; write them only while
// no transaction is in flight.
module vertex_affine_projective_transform_top #(
    parameter int VERTEX_WIDTH = 32,
    parameter int COEF_WIDTH   = 20,
    localparam int CFG_W = (3 * COEF_WIDTH > VERTEX_WIDTH) ? 3 * COEF_WIDTH : VERTEX_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input transactions
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [vapt_pkg::CMD_W-1:0]           command,
    input  logic signed [VERTEX_WIDTH-1:0]       vertex_x,
    input  logic signed [VERTEX_WIDTH-1:0]       vertex_y,
    input  logic signed [VERTEX_WIDTH-1:0]       vertex_z,
    // result transactions
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [VERTEX_WIDTH-1:0]       result_x,
    output logic signed [VERTEX_WIDTH-1:0]       result_y,
    output logic signed [VERTEX_WIDTH-1:0]       result_z,
    output logic                                 saturated,
    output logic                                 divide_by_zero,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vapt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]                     cfg_data
);

    localparam int VW = VERTEX_WIDTH;
    localparam int CW = COEF_WIDTH;
    localparam int DW = VW + CW + 2;
    localparam int QW_ITEM = vapt_pkg::FLAGS_W + 3 * VW + 3 * DW;

    // identity matrix and perspective row at reset
    localparam logic [3*CW-1:0] ROW0_RST = (3*CW)'(1) << vapt_pkg::COEF_FRAC;
    localparam logic [3*CW-1:0] ROW1_RST = (3*CW)'(1) << (vapt_pkg::COEF_FRAC + CW);
    localparam logic [3*CW-1:0] ROW2_RST = (3*CW)'(1) << (vapt_pkg::COEF_FRAC + 2 * CW);

    logic [3*CW-1:0]     row0_reg, row1_reg, row2_reg, persp_reg;
    logic signed [VW-1:0] offx_reg, offy_reg, offz_reg;

    // front to queue and queue to back
    logic                  f_push, q_full, q_empty, q_pop;
    vapt_pkg::item_flags_t f_flags, b_flags;
    logic [VW-1:0]         f_rx, f_ry, f_rz, b_rx, b_ry, b_rz;
    logic [DW-1:0]         f_nx, f_ny, f_den, b_nx, b_ny, b_den;
    logic [QW_ITEM-1:0]    q_din, q_dout;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_reg  <= ROW0_RST;
            row1_reg  <= ROW1_RST;
            row2_reg  <= ROW2_RST;
            persp_reg <= ROW2_RST;
            offx_reg  <= '0;
            offy_reg  <= '0;
            offz_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                vapt_pkg::REG_ROW0:     row0_reg  <= cfg_data[3*CW-1:0];
                vapt_pkg::REG_ROW1:     row1_reg  <= cfg_data[3*CW-1:0];
                vapt_pkg::REG_ROW2:     row2_reg  <= cfg_data[3*CW-1:0];
                vapt_pkg::REG_OFFSET_X: offx_reg  <= cfg_data[VW-1:0];
                vapt_pkg::REG_OFFSET_Y: offy_reg  <= cfg_data[VW-1:0];
                vapt_pkg::REG_OFFSET_Z: offz_reg  <= cfg_data[VW-1:0];
                vapt_pkg::REG_PERSP:    persp_reg <= cfg_data[3*CW-1:0];
                default:                ;
            endcase
        end
    end

    // products, dot sums, rounding and classification
    vapt_front #(
        .VW (VW),
        .CW (CW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .vertex_x (vertex_x),
        .vertex_y (vertex_y),
        .vertex_z (vertex_z),
        .row0     (row0_reg),
        .row1     (row1_reg),
        .row2     (row2_reg),
        .persp    (persp_reg),
        .off_x    (offx_reg),
        .off_y    (offy_reg),
        .off_z    (offz_reg),
        .q_full   (q_full),
        .q_push   (f_push),
        .q_flags  (f_flags),
        .q_rx     (f_rx),
        .q_ry     (f_ry),
        .q_rz     (f_rz),
        .q_nx     (f_nx),
        .q_ny     (f_ny),
        .q_den    (f_den)
    );

    assign q_din = {f_flags, f_rx, f_ry, f_rz, f_nx, f_ny, f_den};
    assign {b_flags, b_rx, b_ry, b_rz, b_nx, b_ny, b_den} = q_dout;

    // short queue so front and back stall independently
    vapt_fifo #(
        .W (QW_ITEM)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    // pipelined divide and output register
    vapt_back #(
        .VW (VW),
        .CW (CW)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .q_flags        (b_flags),
        .q_rx           (b_rx),
        .q_ry           (b_ry),
        .q_rz           (b_rz),
        .q_nx           (b_nx),
        .q_ny           (b_ny),
        .q_den          (b_den),
        .off_x          (offx_reg),
        .off_y          (offy_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_x       (result_x),
        .result_y       (result_y),
        .result_z       (result_z),
        .saturated      (saturated),
        .divide_by_zero (divide_by_zero)
    );

endmodule

@@ design/vapt_checker.sv @@
`include "vertex_affine_projective_transform_top_defines.svh"

module vapt_checker #(
    parameter int VW = 32
) (
    input logic          clk,
    input logic          rst_n,
    input logic          out_valid,
    input logic          out_stall,
    input logic [VW-1:0] result_x,
    input logic [VW-1:0] result_y,
    input logic [VW-1:0] result_z,
    input logic          saturated,
    input logic          divide_by_zero
);

    localparam logic [VW-1:0] MAXR = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] MINR = ~MAXR;

    // a stalled result holds
    `VAPT_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable({result_x, result_y, result_z, saturated, divide_by_zero}))

    // zero divisor always reports a clamp
    `VAPT_ASSERT_NOW(a_dz_sat, clk, rst_n, out_valid && divide_by_zero, saturated)

    // zero divisor drives x to an extreme
    `VAPT_ASSERT_NOW(a_dz_x, clk, rst_n, out_valid && divide_by_zero, result_x == MAXR || result_x == MINR)

    // zero divisor drives y to an extreme
    `VAPT_ASSERT_NOW(a_dz_y, clk, rst_n, out_valid && divide_by_zero, result_y == MAXR || result_y == MINR)

endmodule

bind vertex_affine_projective_transform_top vapt_checker #(
    .VW (VERTEX_WIDTH)
) u_vapt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_x       (result_x),
    .result_y       (result_y),
    .result_z       (result_z),
    .saturated      (saturated),
    .divide_by_zero (divide_by_zero)
);
